FILE: src/sibf_pkg.sv
`timescale 1ns / 1ps

package sibf_pkg;

    localparam int unsigned COORD_W  = 25;
    localparam int unsigned LAT_W    = 24;
    localparam int unsigned EXT_W    = 31;
    localparam int unsigned CELL_W   = 8;
    localparam int unsigned ID_W     = 31;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [31:0] MAX_MATCHES_DEF = 32'd65535;

    localparam logic [CELL_W-1:0] CELL_MAX = 8'd255;

    // operation field
    localparam logic OPER_QUERY  = 1'b0;
    localparam logic OPER_RECORD = 1'b1;

    // result kind
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOUTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EAST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORTH = 2'd3;

endpackage

FILE: src/spatial_index_box_filter.sv
`timescale 1ns / 1ps
// Query beat: each grid cell goes through one shared restoring divider (difference, scale,
// numerator, 9 compare/subtract steps; a flat axis, negative numerator or clamp ends early):
// two cells in point mode, six in box mode (six cells), not ready meanwhile; none outside.
// Record beat: one per cycle while the output is free and no end beat is pending, result
// registered on acceptance; a final matching record holds the input until its end beat issues.
// Synchronous active-low reset clears bounds, query state, count and output valid.
module spatial_index_box_filter
    import sibf_pkg::*;
#(
    parameter logic [31:0] MAX_MATCHES = MAX_MATCHES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic signed [LAT_W-1:0]   s_query_lat,
    input  logic signed [COORD_W-1:0] s_query_lon,
    input  logic [EXT_W-1:0]          s_query_width,
    input  logic [EXT_W-1:0]          s_query_height,
    input  logic [CELL_W-1:0]         s_rec_min_x,
    input  logic [CELL_W-1:0]         s_rec_min_y,
    input  logic [CELL_W-1:0]         s_rec_max_x,
    input  logic [CELL_W-1:0]         s_rec_max_y,
    input  logic [ID_W-1:0]           s_rec_id,
    input  logic                      s_rec_final,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_result_kind,
    output logic [ID_W-1:0]           m_match_id,
    output logic [COUNT_W-1:0]        m_total_matches,
    output logic                      m_run_last
);

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_MATCHES < 32'd65535) ? MAX_MATCHES[COUNT_W-1:0] : {COUNT_W{1'b1}};

    localparam int unsigned DIFF_W = COORD_W + 1;
    localparam int unsigned T_W    = 35;
    localparam int unsigned NUM_W  = 44;
    localparam int unsigned REM_W  = 42;
    localparam int unsigned DEN_W  = 32;
    localparam int unsigned DVS_W  = DEN_W + CELL_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_NUMER = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    // cell jobs; bit 0 picks the axis (0 latitude, 1 longitude)
    localparam logic [2:0] OP_TOP    = 3'd0;
    localparam logic [2:0] OP_RIGHT  = 3'd1;
    localparam logic [2:0] OP_BOTTOM = 3'd2;
    localparam logic [2:0] OP_LEFT   = 3'd3;
    localparam logic [2:0] OP_GRID_Y = 3'd4;
    localparam logic [2:0] OP_GRID_X = 3'd5;

    localparam logic [3:0] BIT_CLAMP = 4'd8;

    // configuration
    logic signed [COORD_W-1:0] west_reg, south_reg, east_reg, north_reg;

    // query state
    logic                    inside_reg, inside_next;
    logic                    box_mode_reg, box_mode_next;
    logic [CELL_W-1:0]       grid_x_reg, grid_x_next, grid_y_reg, grid_y_next;
    logic [CELL_W-1:0]       box_left_reg, box_left_next, box_right_reg, box_right_next;
    logic [CELL_W-1:0]       box_top_reg, box_top_next, box_bottom_reg, box_bottom_next;
    logic [COUNT_W-1:0]      hit_count_reg, hit_count_next;
    logic signed [LAT_W-1:0]   q_lat_reg, q_lat_next;
    logic signed [COORD_W-1:0] q_lon_reg, q_lon_next;
    logic [EXT_W-1:0]        q_w_reg, q_w_next, q_h_reg, q_h_next;

    // sequencer and shared divider
    logic [2:0]              state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next, span_reg, span_next;
    logic signed [T_W-1:0]   t_reg, t_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [3:0]              bit_reg, bit_next;
    logic [CELL_W-1:0]       quo_reg, quo_next;

    // output stage
    logic                    m_valid_reg, m_valid_next;
    logic                    kind_reg, kind_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [COUNT_W-1:0]      total_reg, total_next;
    logic                    last_reg, last_next;
    logic                    pend_reg, pend_next;
    logic [COUNT_W-1:0]      pend_count_reg, pend_count_next;

    logic                    out_free, accept, in_tile, hit;
    logic [COUNT_W-1:0]      count_inc;
    logic signed [COORD_W-1:0] lat_ext, sel_lo, sel_hi, sel_p;
    logic signed [31:0]      ext_val;
    logic signed [NUM_W-1:0] num;
    logic                    ge;
    logic                    done;
    logic [CELL_W-1:0]       cell_val;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free && !pend_reg;
    assign accept   = s_valid && s_ready;

    assign lat_ext = COORD_W'(s_query_lat);
    assign in_tile = (s_query_lon >= west_reg) && (s_query_lon <= east_reg) &&
                     (lat_ext >= south_reg) && (lat_ext <= north_reg);

    always_comb begin
        if (box_mode_reg) begin
            hit = (box_left_reg <= s_rec_min_x) && (box_right_reg >= s_rec_max_x) &&
                  (box_top_reg >= s_rec_max_y) && (box_bottom_reg <= s_rec_min_y);
        end else begin
            hit = (grid_x_reg >= s_rec_min_x) && (grid_x_reg <= s_rec_max_x) &&
                  (grid_y_reg >= s_rec_min_y) && (grid_y_reg <= s_rec_max_y);
        end
        hit = hit && inside_reg;
    end

    assign count_inc = (hit && (hit_count_reg < COUNT_CAP)) ?
                       hit_count_reg + 1'b1 : hit_count_reg;

    // operand selection for the current cell job
    always_comb begin
        if (op_reg[0]) begin
            sel_p  = q_lon_reg;
            sel_lo = west_reg;
            sel_hi = east_reg;
        end else begin
            sel_p  = COORD_W'(q_lat_reg);
            sel_lo = south_reg;
            sel_hi = north_reg;
        end
        case (op_reg)
            OP_TOP:    ext_val = $signed({1'b0, q_h_reg});
            OP_RIGHT:  ext_val = $signed({1'b0, q_w_reg});
            OP_BOTTOM: ext_val = -$signed({1'b0, q_h_reg});
            OP_LEFT:   ext_val = -$signed({1'b0, q_w_reg});
            default:   ext_val = '0;
        endcase
    end

    assign num = (NUM_W'(t_reg) <<< 8) - NUM_W'(t_reg);
    assign ge  = rem_reg >= REM_W'(dvs_reg);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        diff_next       = diff_reg;
        span_next       = span_reg;
        t_next          = t_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        bit_next        = bit_reg;
        quo_next        = quo_reg;
        inside_next     = inside_reg;
        box_mode_next   = box_mode_reg;
        grid_x_next     = grid_x_reg;
        grid_y_next     = grid_y_reg;
        box_left_next   = box_left_reg;
        box_right_next  = box_right_reg;
        box_top_next    = box_top_reg;
        box_bottom_next = box_bottom_reg;
        hit_count_next  = hit_count_reg;
        q_lat_next      = q_lat_reg;
        q_lon_next      = q_lon_reg;
        q_w_next        = q_w_reg;
        q_h_next        = q_h_reg;
        done            = 1'b0;
        cell_val        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OPER_QUERY) begin
                    q_lat_next      = s_query_lat;
                    q_lon_next      = s_query_lon;
                    q_w_next        = s_query_width;
                    q_h_next        = s_query_height;
                    hit_count_next  = '0;
                    inside_next     = in_tile;
                    box_mode_next   = in_tile && (s_query_width != '0) &&
                                      (s_query_height != '0);
                    grid_x_next     = '0;
                    grid_y_next     = '0;
                    box_left_next   = '0;
                    box_right_next  = '0;
                    box_top_next    = '0;
                    box_bottom_next = '0;
                    if (in_tile) begin
                        op_next    = box_mode_next ? OP_TOP : OP_GRID_Y;
                        state_next = ST_DIFF;
                    end
                end else if (accept) begin
                    hit_count_next = s_rec_final ? '0 : count_inc;
                end
            end
            ST_DIFF: begin
                diff_next  = DIFF_W'(sel_p) - DIFF_W'(sel_lo);
                span_next  = DIFF_W'(sel_hi) - DIFF_W'(sel_lo);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (span_reg == '0) begin
                    done = 1'b1;   // flat axis gives cell 0
                end else begin
                    t_next   = (T_W'(diff_reg) <<< 7) - (T_W'(diff_reg) <<< 3) +
                               T_W'(ext_val);
                    den_next = (DEN_W'(span_reg) << 7) - (DEN_W'(span_reg) << 3);
                    state_next = ST_NUMER;
                end
            end
            ST_NUMER: begin
                if (num < 0) begin
                    done = 1'b1;   // negative quotient clamps to 0
                end else begin
                    rem_next   = num[REM_W-1:0];
                    dvs_next   = {den_reg, {CELL_W{1'b0}}};
                    bit_next   = BIT_CLAMP;
                    quo_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                dvs_next = dvs_reg >> 1;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == BIT_CLAMP) begin
                    if (ge) begin
                        done     = 1'b1;
                        cell_val = CELL_MAX;
                    end
                end else begin
                    if (ge) begin
                        rem_next = rem_reg - REM_W'(dvs_reg);
                        quo_next[bit_reg[2:0]] = 1'b1;
                    end
                    if (bit_reg == 4'd0) begin
                        done     = 1'b1;
                        cell_val = quo_next;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (done) begin
            case (op_reg)
                OP_TOP:    box_top_next    = cell_val;
                OP_RIGHT:  box_right_next  = cell_val;
                OP_BOTTOM: box_bottom_next = cell_val;
                OP_LEFT:   box_left_next   = cell_val;
                OP_GRID_Y: grid_y_next     = cell_val;
                default:   grid_x_next     = cell_val;
            endcase
            if (op_reg == OP_GRID_X) begin
                state_next = ST_IDLE;
            end else begin
                op_next    = op_reg + 1'b1;
                state_next = ST_DIFF;
            end
        end
    end

    // output stage: a final record that matches leaves its end beat pending
    always_comb begin
        m_valid_next    = m_valid_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        pend_count_next = pend_count_reg;

        if (pend_reg && out_free) begin
            m_valid_next = 1'b1;
            kind_next    = KIND_END;
            id_next      = '0;
            total_next   = pend_count_reg;
            last_next    = 1'b1;
            pend_next    = 1'b0;
        end else if (accept && s_operation == OPER_RECORD && (hit || s_rec_final)) begin
            m_valid_next = 1'b1;
            if (hit) begin
                kind_next       = KIND_MATCH;
                id_next         = s_rec_id;
                total_next      = '0;
                last_next       = 1'b0;
                pend_next       = s_rec_final;
                pend_count_next = count_inc;
            end else begin
                kind_next  = KIND_END;
                id_next    = '0;
                total_next = count_inc;
                last_next  = 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            west_reg       <= '0;
            south_reg      <= '0;
            east_reg       <= '0;
            north_reg      <= '0;
            state_reg      <= ST_IDLE;
            op_reg         <= OP_TOP;
            inside_reg     <= 1'b0;
            box_mode_reg   <= 1'b0;
            grid_x_reg     <= '0;
            grid_y_reg     <= '0;
            box_left_reg   <= '0;
            box_right_reg  <= '0;
            box_top_reg    <= '0;
            box_bottom_reg <= '0;
            hit_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_WEST:  west_reg  <= cfg_wdata;
                    REG_SOUTH: south_reg <= cfg_wdata;
                    REG_EAST:  east_reg  <= cfg_wdata;
                    REG_NORTH: north_reg <= cfg_wdata;
                    default:   ;
                endcase
            end
            state_reg      <= state_next;
            op_reg         <= op_next;
            inside_reg     <= inside_next;
            box_mode_reg   <= box_mode_next;
            grid_x_reg     <= grid_x_next;
            grid_y_reg     <= grid_y_next;
            box_left_reg   <= box_left_next;
            box_right_reg  <= box_right_next;
            box_top_reg    <= box_top_next;
            box_bottom_reg <= box_bottom_next;
            hit_count_reg  <= hit_count_next;
            m_valid_reg    <= m_valid_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_lat_reg      <= q_lat_next;
        q_lon_reg      <= q_lon_next;
        q_w_reg        <= q_w_next;
        q_h_reg        <= q_h_next;
        diff_reg       <= diff_next;
        span_reg       <= span_next;
        t_reg          <= t_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        bit_reg        <= bit_next;
        quo_reg        <= quo_next;
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        total_reg      <= total_next;
        last_reg       <= last_next;
        pend_count_reg <= pend_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_match_id      = id_reg;
    assign m_total_matches = total_reg;
    assign m_run_last      = last_reg;

endmodule
